/* rtl/core/ssc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sponge stream cipher package
// Shared item codes, permutation constants and the memory request type.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Item mode codes.
  localparam logic [2:0] MODE_ABSORB    = 3'd0;
  localparam logic [2:0] MODE_ENCRYPT   = 3'd1;
  localparam logic [2:0] MODE_DECRYPT   = 3'd2;
  localparam logic [2:0] MODE_SQZ_FIRST = 3'd3;
  localparam logic [2:0] MODE_SQZ_NEXT  = 3'd4;

  // Absorb position at which a shuffle runs before the next nibble swap.
  localparam logic [7:0] SHUFFLE_AT  = 8'd241;
  // Nibble swaps target entries 240 to 255, whose high nibble is all ones.
  localparam logic [3:0] NIBBLE_HIGH = 4'hF;
  localparam logic [7:0] STEP_INC    = 8'd2;
  localparam logic [7:0] STEP_INIT   = 8'd1;
  // Last value of the clearing and shuffle counters.
  localparam logic [7:0] COUNT_LAST  = 8'hFF;

  // One cycle of traffic to the permutation memory.
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } ram_req_t;

endpackage : ssc_pkg
`default_nettype wire

/* rtl/core/ssc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sponge stream cipher channel interfaces
// Valid/ready channels for input items and result bytes.
// ----------------------------------------------------------------------------
interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface : ssc_in_if

interface ssc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface : ssc_out_if
`default_nettype wire

/* rtl/core/sponge_stream_cipher_byte.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sponge stream cipher, byte serial
// Spritz-style sponge over a 256-byte permutation held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   item carries one beat per operation: mode (absorb key byte, encrypt,
//   decrypt, squeeze first, squeeze next) and data_byte. result carries one
//   beat of out_byte for every encrypt, decrypt or squeeze item; absorb and
//   unused mode codes produce no result beat.
//   The block works on one item at a time; item.ready is high only while it
//   is waiting for work. Every permutation access goes through the single
//   memory port, one access per cycle. Encrypt, decrypt and squeeze next
//   each run one update, each absorbed byte takes two nibble swaps, and a
//   shuffle is 256 updates. A shuffle runs before the first squeeze and
//   whenever the absorb position reaches 241.
//   After reset the block writes the identity permutation into the memory,
//   one entry per cycle, all 256 entries, before it first raises item.ready.
//   Results go out through an output register. While a result waits there,
//   the next item is still taken and worked on; only when a second result
//   is finished and the register is still full does the block hold.
// ----------------------------------------------------------------------------
module sponge_stream_cipher_byte (
  input  logic       clk,
  input  logic       rst,
  ssc_in_if.sink     item,
  ssc_out_if.source  result
);
  import ssc_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       res_valid;
  logic       res_ready;
  logic [7:0] res_byte;
  logic       out_valid;
  logic [7:0] out_byte;

  // The permutation itself.
  ssc_perm_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Update, nibble swap and shuffle sequencing plus the index registers.
  ssc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_mode   (item.mode),
    .in_data   (item.data_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_byte  (res_byte),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Output register: it can take a new result in the same cycle that the
  // current one is handed over.
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_byte <= res_byte;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;

endmodule : sponge_stream_cipher_byte
`default_nettype wire

/* rtl/core/ssc_perm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Permutation memory
// 256 x 8 synchronous memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssc_perm_ram (
  input  logic              clk,
  input  ssc_pkg::ram_req_t req,
  output logic [7:0]        rdata
);
  import ssc_pkg::*;

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule : ssc_perm_ram
`default_nettype wire

/* rtl/core/ssc_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sponge stream cipher sequencer
// Holds the indices and runs updates, nibble swaps and shuffles against the
// permutation memory one access at a time.
// ----------------------------------------------------------------------------
module ssc_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_mode,
  input  logic [7:0]        in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        res_byte,
  output ssc_pkg::ram_req_t ram_req,
  input  logic [7:0]        ram_rdata
);
  import ssc_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_U0    = 13'b0000000000100,
    S_U1    = 13'b0000000001000,
    S_U2    = 13'b0000000010000,
    S_U3    = 13'b0000000100000,
    S_U4    = 13'b0000001000000,
    S_NCHK  = 13'b0000010000000,
    S_N0    = 13'b0000100000000,
    S_N1    = 13'b0001000000000,
    S_N2    = 13'b0010000000000,
    S_N3    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t     state;
  logic [7:0] clr_cnt;
  logic [7:0] absorb_pos;
  logic [7:0] idx_i;
  logic [7:0] idx_j;
  logic [7:0] step_w;
  logic       shuf_active;
  logic [7:0] shuf_cnt;
  logic [2:0] mode_q;
  logic       nib_hi;
  logic [7:0] data_q;
  logic [7:0] abs_byte;
  logic [7:0] tmp;
  logic [7:0] res_q;
  logic [3:0] nib;
  logic [7:0] xored;

  assign nib       = nib_hi ? abs_byte[7:4] : abs_byte[3:0];
  assign xored     = data_q ^ tmp;
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_byte  = res_q;

  // Memory traffic: reads are issued in the state before the one that uses their data.
  always_comb begin
    ram_req = '0;
    unique case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt;
        ram_req.wdata = clr_cnt;
      end
      S_U0: ram_req.raddr = idx_i + step_w;
      S_U1: ram_req.raddr = idx_j + ram_rdata;
      S_U2: ram_req.raddr = ram_rdata;
      S_U3: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_i;
        ram_req.wdata = ram_rdata;
      end
      S_U4: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_j;
        ram_req.wdata = tmp;
      end
      S_N0: ram_req.raddr = absorb_pos;
      S_N1: ram_req.raddr = {NIBBLE_HIGH, nib};
      S_N2: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = absorb_pos;
        ram_req.wdata = ram_rdata;
      end
      S_N3: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = {NIBBLE_HIGH, nib};
        ram_req.wdata = tmp;
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      absorb_pos  <= '0;
      idx_i       <= '0;
      idx_j       <= '0;
      step_w      <= STEP_INIT;
      shuf_active <= 1'b0;
      shuf_cnt    <= '0;
      mode_q      <= MODE_ABSORB;
      nib_hi      <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 8'd1;
          if (clr_cnt == COUNT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= in_mode;
            data_q <= in_data;
            unique case (in_mode)
              MODE_ABSORB: begin
                idx_j    <= idx_j + in_data;
                abs_byte <= in_data;
                nib_hi   <= 1'b0;
                state    <= S_NCHK;
              end
              MODE_ENCRYPT, MODE_DECRYPT, MODE_SQZ_NEXT: begin
                state <= S_U0;
              end
              MODE_SQZ_FIRST: begin
                shuf_active <= 1'b1;
                shuf_cnt    <= '0;
                state       <= S_U0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_U0: begin
          idx_i <= idx_i + step_w;
          state <= S_U1;
        end
        S_U1: begin
          tmp   <= ram_rdata;
          state <= S_U2;
        end
        S_U2: begin
          idx_j <= ram_rdata;
          state <= S_U3;
        end
        S_U3: state <= S_U4;
        S_U4: begin
          if (shuf_active) begin
            if (shuf_cnt != COUNT_LAST) begin
              shuf_cnt <= shuf_cnt + 8'd1;
              state    <= S_U0;
            end else begin
              shuf_active <= 1'b0;
              step_w      <= step_w + STEP_INC;
              absorb_pos  <= '0;
              // A squeeze goes on to its emitting update; an absorb, encrypt or decrypt
              // resumes the nibble swap that was waiting for the shuffle.
              state <= (mode_q == MODE_SQZ_FIRST) ? S_U0 : S_N0;
            end
          end else begin
            // After the swap, perm[idx_j] holds the value read at idx_i.
            unique case (mode_q)
              MODE_ENCRYPT: begin
                res_q    <= xored;
                abs_byte <= xored;
                idx_j    <= idx_j + xored;
                nib_hi   <= 1'b0;
                state    <= S_NCHK;
              end
              MODE_DECRYPT: begin
                res_q    <= xored;
                abs_byte <= data_q;
                idx_j    <= idx_j + data_q;
                nib_hi   <= 1'b0;
                state    <= S_NCHK;
              end
              default: begin
                res_q <= tmp;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_NCHK: begin
          if (absorb_pos == SHUFFLE_AT) begin
            shuf_active <= 1'b1;
            shuf_cnt    <= '0;
            state       <= S_U0;
          end else begin
            state <= S_N0;
          end
        end
        S_N0: state <= S_N1;
        S_N1: begin
          tmp   <= ram_rdata;
          state <= S_N2;
        end
        S_N2: state <= S_N3;
        S_N3: begin
          absorb_pos <= absorb_pos + 8'd1;
          if (!nib_hi) begin
            nib_hi <= 1'b1;
            state  <= S_NCHK;
          end else begin
            state <= (mode_q == MODE_ABSORB) ? S_IDLE : S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    absorb_pos <= SHUFFLE_AT)
    else $error("absorb position passed the shuffle point");

  a_step_odd: assert property (@(posedge clk) disable iff (rst)
    step_w[0])
    else $error("step became even");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ram_req.we)
    else $error("memory written while no item is in work");

  a_shuffle_in_update: assert property (@(posedge clk) disable iff (rst)
    shuf_active |-> (state == S_U0 || state == S_U1 || state == S_U2 ||
                     state == S_U3 || state == S_U4))
    else $error("shuffle flag set outside the update steps");
`endif

endmodule : ssc_seq
`default_nettype wire

/* tb/tb_sponge_stream_cipher_byte.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sponge stream cipher testbench
// Drives absorb, encrypt, decrypt and squeeze beats into the block under
// random back-pressure on both channels. A bit-exact software copy of the
// permutation state predicts every result byte, and a scoreboard checks the
// bytes in order.
// ----------------------------------------------------------------------------
module tb_sponge_stream_cipher_byte;
  import ssc_pkg::*;

  // Mode codes the block must ignore: no state change, no result beat.
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  // Random beats that carry a real operation; spare-code beats are extra.
  localparam int RANDOM_ITEMS = 1950;
  // Cycles allowed after the last result for the block to settle.
  localparam int DRAIN_CYCLES = 40;
  // Timeout. A slow correct run of this stimulus adds up every beat held
  // off by long gaps on both sides, a shuffle for each first squeeze and
  // each wrap of the absorb position, and the clearing pass after reset.
  localparam int CYCLE_LIMIT = 2_000_000;

  // Keeps a copy of the permutation state and the queue of result bytes
  // that are still owed by the block.
  class keystream_scoreboard;
    logic [7:0] perm [256];
    logic [7:0] absorb_pos;
    logic [7:0] idx_i;
    logic [7:0] idx_j;
    logic [7:0] step_w;
    logic [7:0] pending_bytes [$];
    int         errors;

    function new();
      for (int k = 0; k < 256; k++) perm[k] = 8'(k);
      absorb_pos = '0;
      idx_i      = '0;
      idx_j      = '0;
      step_w     = STEP_INIT;
      errors     = 0;
    endfunction

    function void swap_entries(logic [7:0] p, logic [7:0] q);
      logic [7:0] tmp;
      tmp     = perm[p];
      perm[p] = perm[q];
      perm[q] = tmp;
    endfunction

    function void run_update();
      logic [7:0] sum;
      idx_i = idx_i + step_w;
      sum   = idx_j + perm[idx_i];
      idx_j = perm[sum];
      swap_entries(idx_i, idx_j);
    endfunction

    function void run_shuffle();
      repeat (256) run_update();
      step_w     = step_w + STEP_INC;
      absorb_pos = '0;
    endfunction

    function void mix_nibble(logic [3:0] nib);
      if (absorb_pos == SHUFFLE_AT) run_shuffle();
      swap_entries(absorb_pos, {NIBBLE_HIGH, nib});
      absorb_pos = absorb_pos + 8'd1;
    endfunction

    function void mix_key_byte(logic [7:0] b);
      idx_j = idx_j + b;
      mix_nibble(b[3:0]);
      mix_nibble(b[7:4]);
    endfunction

    function logic [7:0] next_keystream();
      run_update();
      return perm[idx_j];
    endfunction

    // Called once per accepted input beat.
    function void note_item(logic [2:0] mode, logic [7:0] data);
      logic [7:0] res;
      case (mode)
        MODE_ABSORB: begin
          mix_key_byte(data);
        end
        MODE_ENCRYPT: begin
          run_update();
          res = data ^ perm[idx_j];
          mix_key_byte(res);
          pending_bytes.push_back(res);
        end
        MODE_DECRYPT: begin
          run_update();
          res = data ^ perm[idx_j];
          mix_key_byte(data);
          pending_bytes.push_back(res);
        end
        MODE_SQZ_FIRST: begin
          run_shuffle();
          pending_bytes.push_back(next_keystream());
        end
        MODE_SQZ_NEXT: begin
          pending_bytes.push_back(next_keystream());
        end
        default: begin
        end
      endcase
    endfunction

    // Called once per accepted result beat.
    function void check_byte(logic [7:0] actual);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: result beat with nothing pending, actual out_byte=%02h",
                 $time, actual);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (actual !== want) begin
          $display("%0t: out_byte mismatch, expected=%02h actual=%02h",
                   $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   items_sent;
  bit   no_idle;

  ssc_in_if  item_ch ();
  ssc_out_if result_ch ();

  keystream_scoreboard sb = new();

  sponge_stream_cipher_byte uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Timeout guard. A hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result monitor. The values read here are the ones that were stable
  // before the edge, so a beat is counted exactly when the block sees it
  // taken.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) sb.check_byte(result_ch.out_byte);
  end

  // Idle length used by both channels: mostly short, now and then
  // long enough that the block fills its output register and holds.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Gap before the next input beat. While no_idle is set, beats go out
  // back to back so that the block sees a continuous stream.
  function automatic int next_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  // Presents one beat and holds it until the block takes it. When the gap
  // is zero, valid stays high from the previous beat and only the payload
  // changes, so each signal gets at most one update per edge.
  task automatic send_item(input logic [2:0] mode, input logic [7:0] data);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      item_ch.valid     <= 1'b0;
      item_ch.mode      <= 3'($urandom);
      item_ch.data_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.mode      <= mode;
    item_ch.data_byte <= data;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(mode, data);
    if (mode <= MODE_SQZ_NEXT) items_sent++;
  endtask

  // Result-side back-pressure: short bursts of ready broken by stalls of
  // mixed length, with the occasional long stretch of ready held high.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 300)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        result_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  initial begin
    int     seq_kind;
    int     seq_len;
    logic [2:0] mode;

    cycles     = 0;
    items_sent = 0;
    no_idle    = 1'b0;
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.mode      <= MODE_ABSORB;
    item_ch.data_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. Key bytes at the value extremes and with one nibble
    // all zeros and the other all ones, then both ciphers at the extremes,
    // squeezes carrying junk data that must be ignored, and every spare
    // mode code in the middle of a stream, which must leave the state alone.
    send_item(MODE_ABSORB, 8'h00);
    send_item(MODE_ABSORB, 8'hFF);
    send_item(MODE_ABSORB, 8'h0F);
    send_item(MODE_ABSORB, 8'hF0);
    send_item(MODE_ABSORB, 8'hA5);
    send_item(MODE_ENCRYPT, 8'h00);
    send_item(MODE_ENCRYPT, 8'hFF);
    send_item(MODE_DECRYPT, 8'h00);
    send_item(MODE_DECRYPT, 8'hFF);
    send_item(MODE_ENCRYPT, 8'h5A);
    send_item(MODE_SQZ_FIRST, 8'hFF);
    send_item(MODE_SQZ_NEXT, 8'h00);
    send_item(MODE_SQZ_NEXT, 8'hFF);
    send_item(MODE_RSVD5, 8'hFF);
    send_item(MODE_RSVD6, 8'h00);
    send_item(MODE_RSVD7, 8'hAA);
    send_item(MODE_DECRYPT, 8'h3C);
    send_item(MODE_SQZ_NEXT, 8'h81);
    send_item(MODE_SQZ_FIRST, 8'h00);
    send_item(MODE_ABSORB, 8'h00);

    // Random part, built from the sequences a real user would issue: key
    // schedules, encrypt and decrypt streams, and a first squeeze followed
    // by a run of squeeze-next beats. A small share is noise with any mode
    // code. Absorb, encrypt and decrypt all advance the absorb position,
    // so it reaches 241 many times and triggers shuffles mid-stream.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      seq_kind = $urandom_range(0, 99);
      if (seq_kind < 25) begin
        seq_len = $urandom_range(1, 24);
        repeat (seq_len) send_item(MODE_ABSORB, 8'($urandom));
      end else if (seq_kind < 50) begin
        seq_len = $urandom_range(1, 20);
        repeat (seq_len) send_item(MODE_ENCRYPT, 8'($urandom));
      end else if (seq_kind < 70) begin
        seq_len = $urandom_range(1, 20);
        repeat (seq_len) send_item(MODE_DECRYPT, 8'($urandom));
      end else if (seq_kind < 78) begin
        send_item(MODE_SQZ_FIRST, 8'($urandom));
        seq_len = $urandom_range(1, 30);
        repeat (seq_len) send_item(MODE_SQZ_NEXT, 8'($urandom));
      end else if (seq_kind < 90) begin
        seq_len = $urandom_range(1, 10);
        repeat (seq_len) send_item(MODE_SQZ_NEXT, 8'($urandom));
      end else begin
        seq_len = $urandom_range(1, 4);
        repeat (seq_len) begin
          mode = 3'($urandom);
          // Keep first squeezes rare so the shuffles stay affordable.
          if (mode == MODE_SQZ_FIRST && $urandom_range(0, 3) != 0) mode = MODE_SQZ_NEXT;
          send_item(mode, 8'($urandom));
        end
      end
    end
    item_ch.valid <= 1'b0;

    // Let every owed result come back, then give the block a little time
    // to show any stray beat.
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
